### hw/rtl/b2b5_pkg.sv
// Package for the binary to base-5 converter.
// Holds the radix constants, the controller/datapath command and status
// structs and the chunked divide-by-five step. Depends on nothing.
package b2b5_pkg;

   localparam int RADIX      = 5;
   localparam int DIGIT_W    = 3;
   localparam int CHUNK_BITS = 8;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture a new value, clear digit state
      logic step;        // divide one chunk of the quotient by five
      logic start_emit;  // point the read index at the top digit
      logic emit;        // move one digit into the output register
   } b2b5_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic divide_done; // quotient exhausted or digit store full
      logic emit_last;   // read index sits on the least significant digit
      logic out_free;    // output register can take a digit this cycle
   } b2b5_sts_type;

   typedef struct packed {
      logic [CHUNK_BITS-1:0] quot;
      logic [DIGIT_W-1:0]    rem;
   } b2b5_div_type;

   // Long division of one chunk by five, most significant bit first.
   // The running remainder stays below five, so each step is a 4-bit compare.
   function automatic b2b5_div_type div5_chunk(input logic [DIGIT_W-1:0]    rem_in,
                                               input logic [CHUNK_BITS-1:0] bits);
      b2b5_div_type     res;
      logic [DIGIT_W:0] part;
      logic [DIGIT_W-1:0] rem;
      rem = rem_in;
      res = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         part = {rem, bits[i]};
         if (part >= (DIGIT_W + 1)'(RADIX)) begin
            res.quot[i] = 1'b1;
            part        = part - (DIGIT_W + 1)'(RADIX);
         end
         rem = part[DIGIT_W-1:0];
      end
      res.rem = rem;
      return res;
   endfunction

endpackage

### hw/rtl/binary_to_base5_converter.sv
// Binary to base-5 converter: takes one unsigned VALUE_BITS-bit integer per
// item and returns its base-5 digits, most significant first, one item per
// digit; the final digit carries last and the number of distinct digit
// values used, and zero gives a single digit 0. At most MAX_DIGITS digits
// are kept (the least significant ones). Each digit takes ceil(VALUE_BITS/8)
// steps of the divide-by-five unit, which handles 8 quotient bits a cycle;
// all digits of an item are found before the first one is emitted. One item
// is worked on at a time; the last digit of one item may still wait at the
// output while the next item is accepted.
// Depends on b2b5_pkg, b2b5_ctrl and b2b5_datapath.
module binary_to_base5_converter
   import b2b5_pkg::*;
#(
   parameter int VALUE_BITS = 31,
   parameter int MAX_DIGITS = 14
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIGIT_W-1:0]    rsp_digit,
   output logic                  rsp_last,
   output logic [DIGIT_W-1:0]    rsp_distinct_digits
);

   b2b5_cmd_type cmd;
   b2b5_sts_type sts;

   b2b5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   b2b5_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_value           (req_value),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_digit           (rsp_digit),
      .rsp_last            (rsp_last),
      .rsp_distinct_digits (rsp_distinct_digits)
   );

endmodule

### hw/rtl/b2b5_ctrl.sv
// Controller of the binary to base-5 converter.
// Sequences load, chunked division and digit emission; uses b2b5_pkg.
module b2b5_ctrl
   import b2b5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  b2b5_sts_type sts,
   output b2b5_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (sts.divide_done) begin
               cmd.start_emit = 1'b1;
               state_in       = S_EMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/b2b5_datapath.sv
// Datapath of the binary to base-5 converter: quotient register with
// chunked divide-by-five, digit store and output register. Uses b2b5_pkg.
module b2b5_datapath
   import b2b5_pkg::*;
#(
   parameter int VALUE_BITS = 31,
   parameter int MAX_DIGITS = 14
)(
   input  logic                  clock,
   input  logic                  reset,
   input  b2b5_cmd_type          cmd,
   output b2b5_sts_type          sts,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [DIGIT_W-1:0]    rsp_digit,
   output logic                  rsp_last,
   output logic [DIGIT_W-1:0]    rsp_distinct_digits
);

   localparam int NCHUNK   = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PAD_BITS = NCHUNK * CHUNK_BITS;
   localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W    = $clog2(MAX_DIGITS);

   logic [PAD_BITS-1:0] work_ff, work_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [RADIX-1:0]    mask_ff, mask_in;
   logic [IDX_W-1:0]    rd_ff, rd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]  rsp_digit_ff;
   logic                rsp_last_ff;
   logic [DIGIT_W-1:0]  rsp_distinct_ff;
   logic [DIGIT_W-1:0]  digit_buf_ff [MAX_DIGITS];

   b2b5_div_type        div;
   logic                chunk_last;
   logic                digit_done;
   logic [DIGIT_W-1:0]  distinct;

   // Divide the top chunk of the working quotient
   always_comb begin
      div        = div5_chunk(rem_ff, work_ff[PAD_BITS-1 -: CHUNK_BITS]);
      chunk_last = (chunk_ff == CHUNK_W'(NCHUNK - 1));
      digit_done = cmd.step && chunk_last;
   end

   // Count distinct digit values seen
   always_comb begin
      distinct = '0;
      for (int i = 0; i < RADIX; i++) begin
         distinct = distinct + DIGIT_W'(mask_ff[i]);
      end
   end

   // Next values of the control registers
   always_comb begin
      work_in      = work_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         work_in  = PAD_BITS'(req_value);
         rem_in   = '0;
         chunk_in = '0;
         count_in = '0;
         mask_in  = '0;
      end
      if (cmd.step) begin
         // rotate the quotient bits in at the bottom
         work_in = (work_ff << CHUNK_BITS) | PAD_BITS'(div.quot);
         if (chunk_last) begin
            rem_in   = '0;
            chunk_in = '0;
            count_in = count_ff + CNT_W'(1);
            mask_in  = mask_ff | (RADIX'(1) << div.rem);
         end else begin
            rem_in   = div.rem;
            chunk_in = chunk_ff + CHUNK_W'(1);
         end
      end
      if (cmd.start_emit) begin
         rd_in = IDX_W'(count_ff - CNT_W'(1));
      end
      if (cmd.emit) begin
         rd_in        = rd_ff - IDX_W'(1);
         rsp_valid_in = 1'b1;
      end
   end

   // Status to the controller
   always_comb begin
      sts.divide_done = (chunk_ff == '0) && (count_ff != '0)
                        && ((work_ff == '0) || (count_ff == CNT_W'(MAX_DIGITS)));
      sts.emit_last   = (rd_ff == '0);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff      <= '0;
         rem_ff       <= '0;
         chunk_ff     <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff      <= work_in;
         rem_ff       <= rem_in;
         chunk_ff     <= chunk_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Store each finished digit, least significant first
   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_buf_ff[count_ff[IDX_W-1:0]] <= div.rem;
      end
   end

   // Load the output register, most significant digit first
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_digit_ff    <= digit_buf_ff[rd_ff];
         rsp_last_ff     <= (rd_ff == '0);
         rsp_distinct_ff <= (rd_ff == '0) ? distinct : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_digit           = rsp_digit_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_distinct_digits = rsp_distinct_ff;

endmodule
